// File: hw/rtl/fuzzy_pid_gain_scheduler_core_assert.svh
// Assertion macros used by the gain scheduler core RTL.
`ifndef FUZZY_PID_GAIN_SCHEDULER_CORE_ASSERT_SVH
`define FUZZY_PID_GAIN_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FPGS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fpgs assertion failed");

// Next-cycle implication, checked outside reset.
`define FPGS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fpgs assertion failed");

`endif

// File: hw/rtl/fpgs_pkg.sv
// Package of the fuzzy PID gain scheduler: types, codes, rule tables.
package fpgs_pkg;

	localparam int LEVEL_COUNT      = 7;
	localparam int WEIGHT_FRAC_BITS = 8;
	localparam int BP_W             = 8 * LEVEL_COUNT;

	typedef enum logic [1:0] {
		OP_P   = 2'd0,
		OP_I   = 2'd1,
		OP_D   = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_ERR_BP = 3'd0,
		REG_CHG_BP = 3'd1,
		REG_KP     = 3'd2,
		REG_KI     = 3'd3,
		REG_KD     = 3'd4
	} reg_idx_t;

	// Result of locating one sample among its seven levels.
	typedef struct packed {
		logic [2:0] idx;
		logic       le;
		logic       ge;
		logic [7:0] num;
		logic [7:0] den;
	} fz_t;

	localparam logic [2:0] TBL_P [LEVEL_COUNT][LEVEL_COUNT] = '{
		'{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3},
		'{3'd6, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2},
		'{3'd5, 3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd2},
		'{3'd5, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd1},
		'{3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1},
		'{3'd4, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0},
		'{3'd3, 3'd3, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0}
	};
	localparam logic [2:0] TBL_I [LEVEL_COUNT][LEVEL_COUNT] = '{
		'{3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3},
		'{3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3},
		'{3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4},
		'{3'd1, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd5},
		'{3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6},
		'{3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6},
		'{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6}
	};
	localparam logic [2:0] TBL_D [LEVEL_COUNT][LEVEL_COUNT] = '{
		'{3'd4, 3'd2, 3'd0, 3'd0, 3'd0, 3'd1, 3'd4},
		'{3'd4, 3'd2, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3},
		'{3'd3, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3},
		'{3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3},
		'{3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3},
		'{3'd6, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd6},
		'{3'd6, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd6}
	};

	// Rule level for change row and error column; rows and columns stay below 7.
	function automatic logic [2:0] rule_level(input op_t op, input logic [2:0] row,
			input logic [2:0] col);
		logic [2:0] lvl;
		lvl = 3'd0;
		if (row < 3'd7 && col < 3'd7) begin
			unique case (op)
				OP_P:    lvl = TBL_P[row][col];
				OP_I:    lvl = TBL_I[row][col];
				OP_D:    lvl = TBL_D[row][col];
				default: lvl = 3'd0;
			endcase
		end
		return lvl;
	endfunction

	function automatic logic [7:0] level_byte(input logic [BP_W-1:0] levels,
			input logic [2:0] lvl);
		return 8'(levels >> {lvl, 3'b000});
	endfunction

endpackage

// File: hw/rtl/fpgs_fuzzify.sv
// Clamp a sample, find its level interval and the operands of its weight.
module fpgs_fuzzify (
	input  logic [fpgs_pkg::BP_W-1:0] levels,
	input  logic signed [7:0]          x,
	output fpgs_pkg::fz_t              fz
);
	import fpgs_pkg::*;

	logic signed [7:0] lv [LEVEL_COUNT];
	logic signed [7:0] xc;
	logic signed [7:0] lo;
	logic signed [7:0] hi;
	logic [2:0]        idx;
	logic signed [8:0] num_w;
	logic signed [8:0] den_w;

	always_comb begin
		for (int k = 0; k < LEVEL_COUNT; k++) begin
			lv[k] = signed'(levels[8*k +: 8]);
		end
		if (x > lv[LEVEL_COUNT-1]) begin
			xc = lv[LEVEL_COUNT-1];
		end else if (x < lv[0]) begin
			xc = lv[0];
		end else begin
			xc = x;
		end
		// first level above the sample wins; scan downward so the lowest sticks
		idx = 3'(LEVEL_COUNT - 2);
		for (int k = LEVEL_COUNT - 2; k >= 1; k--) begin
			if (xc < lv[k]) begin
				idx = 3'(k - 1);
			end
		end
		lo    = lv[idx];
		hi    = lv[3'(idx + 3'd1)];
		num_w = 9'(xc) - 9'(lo);
		den_w = 9'(hi) - 9'(lo);
		fz.idx = idx;
		fz.le  = (xc <= lo);
		fz.ge  = (xc >= hi);
		fz.num = num_w[7:0];
		fz.den = den_w[7:0];
	end

endmodule

// File: hw/rtl/fuzzy_pid_gain_scheduler_core.sv
// Fuzzy PID gain scheduler top level: config registers and weight pipeline.
// Stages from sample request to gain request: one locate stage, one divider
// stage per weight bit, then weight product, gain product and sum/round stages.
// Throughput: one request per cycle while gain_ready is high; a stalled stage
// holds, bubbles collapse.
// Reset clears all config registers and pipeline valid bits at once.
module fuzzy_pid_gain_scheduler_core #(
	parameter int WEIGHT_FRAC_BITS = fpgs_pkg::WEIGHT_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// sample channel
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic signed [7:0] error_sample,
	input  logic signed [7:0] error_change,
	input  logic [1:0]  operation,
	// gain channel
	output logic        gain_valid,
	input  logic        gain_ready,
	output logic [15:0] gain_value
);
	import fpgs_pkg::*;

	`include "fuzzy_pid_gain_scheduler_core_assert.svh"

	localparam int W      = WEIGHT_FRAC_BITS;
	localparam int NST    = W + 4;            // locate, W divider steps, 3 back stages
	localparam int WW     = W + 1;            // weight width, holds ONE
	localparam int PW     = 2 * WW;           // weight product width
	localparam int TW     = PW + 8;           // gain term width
	localparam int SW     = TW + 2;           // sum of four terms
	localparam int SH     = 2 * W - 8;
	localparam int RND    = (1 << SH) >> 1;   // half an output lsb, zero when no shift
	localparam logic [WW-1:0] ONE = WW'(1) << W;

	// ---------------------------------------------------------------
	// Config registers; pready stays high so every access completes
	// ---------------------------------------------------------------
	logic [BP_W-1:0] err_bp_q, chg_bp_q, kp_q, ki_q, kd_q;
	reg_idx_t        cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_bp_q <= '0;
			chg_bp_q <= '0;
			kp_q     <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_sel)
				REG_ERR_BP: err_bp_q <= pwdata[BP_W-1:0];
				REG_CHG_BP: chg_bp_q <= pwdata[BP_W-1:0];
				REG_KP:     kp_q     <= pwdata[BP_W-1:0];
				REG_KI:     ki_q     <= pwdata[BP_W-1:0];
				REG_KD:     kd_q     <= pwdata[BP_W-1:0];
				default:    ;   // drop writes past the register list
			endcase
		end
	end

	always_comb begin
		unique case (cfg_sel)
			REG_ERR_BP: prdata = 64'(err_bp_q);
			REG_CHG_BP: prdata = 64'(chg_bp_q);
			REG_KP:     prdata = 64'(kp_q);
			REG_KI:     prdata = 64'(ki_q);
			REG_KD:     prdata = 64'(kd_q);
			default:    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Pipeline flow control: a stage loads when empty or draining
	// ---------------------------------------------------------------
	logic [NST-1:0] vld_q;
	logic [NST-1:0] adv;

	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || gain_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= sample_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign sample_ready = adv[0];
	assign gain_valid   = vld_q[NST-1];

	// ---------------------------------------------------------------
	// Stage 1: clamp and locate both samples
	// ---------------------------------------------------------------
	fz_t fz_e, fz_c;
	fz_t fz_e_s1, fz_c_s1;
	op_t op_s1;

	fpgs_fuzzify u_fz_err (.levels(err_bp_q), .x(error_sample), .fz(fz_e));
	fpgs_fuzzify u_fz_chg (.levels(chg_bp_q), .x(error_change), .fz(fz_c));

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			fz_e_s1 <= fz_e;
			fz_c_s1 <= fz_c;
			op_s1   <= op_t'(operation);
		end
	end

	// ---------------------------------------------------------------
	// Divider: restoring, one quotient bit per stage for each lane
	// ---------------------------------------------------------------
	typedef struct packed {
		logic [7:0]   rem;
		logic [W-1:0] quo;
		logic [7:0]   den;
		logic         le;
		logic         ge;
		logic [2:0]   idx;
	} lane_t;

	lane_t dv_e_q [W];
	lane_t dv_c_q [W];
	op_t   dv_op_q [W];

	function automatic lane_t div_step(input lane_t a);
		lane_t      b;
		logic [8:0] t;
		b = a;
		t = {a.rem, 1'b0};
		if (t >= {1'b0, a.den}) begin
			b.rem = 8'(t - {1'b0, a.den});
			b.quo = {a.quo[W-2:0], 1'b1};
		end else begin
			b.rem = t[7:0];
			b.quo = {a.quo[W-2:0], 1'b0};
		end
		return b;
	endfunction

	function automatic lane_t lane_init(input fz_t f);
		lane_t l;
		l.rem = f.num;
		l.quo = '0;
		l.den = f.den;
		l.le  = f.le;
		l.ge  = f.ge;
		l.idx = f.idx;
		return l;
	endfunction

	for (genvar j = 0; j < W; j++) begin : g_div
		lane_t in_e, in_c;
		op_t   in_op;
		if (j == 0) begin : g_first
			assign in_e  = lane_init(fz_e_s1);
			assign in_c  = lane_init(fz_c_s1);
			assign in_op = op_s1;
		end else begin : g_next
			assign in_e  = dv_e_q[j-1];
			assign in_c  = dv_c_q[j-1];
			assign in_op = dv_op_q[j-1];
		end
		always_ff @(posedge clk) begin
			if (adv[j+1]) begin
				dv_e_q[j]  <= div_step(in_e);
				dv_c_q[j]  <= div_step(in_c);
				dv_op_q[j] <= in_op;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage W+2: weights, their pairwise products, rule gain lookup
	// ---------------------------------------------------------------
	lane_t           le_fin, lc_fin;
	op_t             op_fin;
	logic [WW-1:0]   we [2];
	logic [WW-1:0]   wc [2];
	logic [BP_W-1:0] gains;
	logic [PW-1:0]   wp_s2 [2][2];
	logic [7:0]      g_s2  [2][2];
	op_t             op_s2;

	assign le_fin = dv_e_q[W-1];
	assign lc_fin = dv_c_q[W-1];
	assign op_fin = dv_op_q[W-1];

	always_comb begin
		we[1] = le_fin.le ? '0 : (le_fin.ge ? ONE : WW'(le_fin.quo));
		wc[1] = lc_fin.le ? '0 : (lc_fin.ge ? ONE : WW'(lc_fin.quo));
		we[0] = ONE - we[1];
		wc[0] = ONE - wc[1];
		case (op_fin)
			OP_P:    gains = kp_q;
			OP_I:    gains = ki_q;
			OP_D:    gains = kd_q;
			default: gains = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[W+1]) begin
			for (int a = 0; a < 2; a++) begin
				for (int b = 0; b < 2; b++) begin
					wp_s2[a][b] <= PW'(wc[a]) * PW'(we[b]);
					g_s2[a][b]  <= level_byte(gains, rule_level(op_fin,
						3'(lc_fin.idx + 3'(a)), 3'(le_fin.idx + 3'(b))));
				end
			end
			op_s2 <= op_fin;
		end
	end

	// ---------------------------------------------------------------
	// Stage W+3: scale each weight product by its rule gain
	// ---------------------------------------------------------------
	logic [TW-1:0] term_s3 [2][2];
	op_t           op_s3;

	always_ff @(posedge clk) begin
		if (adv[W+2]) begin
			for (int a = 0; a < 2; a++) begin
				for (int b = 0; b < 2; b++) begin
					term_s3[a][b] <= TW'(g_s2[a][b]) * TW'(wp_s2[a][b]);
				end
			end
			op_s3 <= op_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage W+4: sum, round half up into Q8.8; this is the output register
	// ---------------------------------------------------------------
	logic [SW-1:0] sum_c;
	logic [15:0]   gain_s4;

	always_comb begin
		sum_c = SW'(term_s3[0][0]) + SW'(term_s3[0][1]) + SW'(term_s3[1][0])
			+ SW'(term_s3[1][1]) + SW'(RND);
	end

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			gain_s4 <= (op_s3 == OP_NONE) ? 16'd0 : 16'(sum_c >> SH);
		end
	end

	assign gain_value = gain_s4;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`FPGS_ASSERT_IMP(a_rem_below_den, vld_q[W] && !le_fin.le && !le_fin.ge,
		le_fin.rem < le_fin.den)
	`FPGS_ASSERT_IMP(a_out_bounded, gain_valid, gain_value <= 16'd65280)
	`FPGS_ASSERT_NXT(a_stall_keeps_item, vld_q[1] && !adv[1], vld_q[1])

endmodule
